// ----- src/quadrature_decode_wheel_sync_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature decode and wheel sync unit
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DECODE_WHEEL_SYNC_UNIT_DEFINES_SVH
`define QUADRATURE_DECODE_WHEEL_SYNC_UNIT_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define QDWS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define QDWS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/qdws_pkg.sv -----
// ----------------------------------------------------------------------------
// Quadrature decode and wheel sync package
// Shared widths, codes, reset values and the quadrature step table.
// ----------------------------------------------------------------------------
package qdws_pkg;

  // Field widths.
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned PINS_W      = 2;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned GAIN_W      = 8;
  localparam int unsigned DRIVE_W     = 15;
  localparam int unsigned TARGET_W    = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 15;

  // Error magnitude limit ahead of the gain multiply, and its signed width.
  localparam int unsigned ERR_LIMIT = 65536;
  localparam int unsigned ERR_W     = 18;

  // Width of gain * error plus target, with room for the sign.
  localparam int unsigned SUM_W = GAIN_W + 1 + ERR_W + 1;

  // Configuration reset values.
  localparam logic [GAIN_W-1:0]  SYNC_GAIN_RST     = 8'd40;
  localparam logic [DRIVE_W-1:0] MAX_DRIVE_RST     = 15'd10000;
  localparam logic               REVERSE_RIGHT_RST = 1'b0;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_GAIN     = 2'd0,
    CFG_MAX_DRIVE     = 2'd1,
    CFG_REVERSE_RIGHT = 2'd2
  } cfg_reg_e;

  // Position step indexed by {new pins, previous pins}.
  localparam logic signed [2:0] STEP_TABLE [16] = '{
    3'sd0,  3'sd1,  -3'sd1, 3'sd2,
    -3'sd1, 3'sd0,  -3'sd2, 3'sd1,
    3'sd1,  -3'sd2, 3'sd0,  -3'sd1,
    3'sd2,  -3'sd1, 3'sd1,  3'sd0
  };

endpackage

// ----- src/quadrature_decode_wheel_sync_unit.sv -----
// ----------------------------------------------------------------------------
// Quadrature decode and wheel sync unit
// Two-wheel quadrature decoder with a proportional loop that steers the
// right wheel drive toward the left wheel's speed.
// ----------------------------------------------------------------------------
// Each request is a pin sample, a control tick or a count clear, and each one
// yields exactly one result with both wheel counts and the right motor drive
// in sign-magnitude form. The unit takes one request per clock cycle when
// not stalled, and each accepted request goes through three internal register
// stages (count delta, delta magnitude, limited error) and the output
// register, where the 9x18 gain multiply, the target add and the drive clamp
// sit. Stages fill bubbles independently, so requests keep flowing while a
// finished result waits on a stalled output. Configuration writes are always
// ready and must be issued while the unit is idle.
module quadrature_decode_wheel_sync_unit #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qdws_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [qdws_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Request channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [qdws_pkg::KIND_W-1:0]         kind_i,
  input  logic [qdws_pkg::PINS_W-1:0]         left_ab_i,
  input  logic [qdws_pkg::PINS_W-1:0]         right_ab_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [qdws_pkg::OUT_COUNT_W-1:0] left_count_o,
  output logic signed [qdws_pkg::OUT_COUNT_W-1:0] right_count_o,
  output logic                                drive_pin_a_o,
  output logic                                drive_pin_b_o,
  output logic [qdws_pkg::DRIVE_W-1:0]        drive_pwm_o
);
  import qdws_pkg::*;

  // Difference width, wide enough to compare against the error limit.
  localparam int unsigned DiffW = (COUNT_BITS > 17) ? COUNT_BITS : 17;

  // Configuration registers.
  logic [GAIN_W-1:0]  sync_gain_q;
  logic [DRIVE_W-1:0] max_drive_q;
  logic               reverse_right_q;

  // Wheel state.
  logic [PINS_W-1:0]     last_left_q, last_right_q;
  logic [COUNT_BITS-1:0] left_pos_q, left_pos_d;
  logic [COUNT_BITS-1:0] right_pos_q, right_pos_d;
  logic [COUNT_BITS-1:0] left_snap_q, right_snap_q;
  logic signed [TARGET_W-1:0] target_q;

  // Pipeline valid bits and handshake chain.
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, out_ready;
  logic in_fire;

  // Stage payloads.
  logic                   s1_tick_q, s2_tick_q, s3_tick_q;
  logic [COUNT_BITS-1:0]  s1_dl_q, s1_dr_q;
  logic [COUNT_BITS-1:0]  s2_ml_q, s2_mr_q;
  logic signed [ERR_W-1:0] s3_err_q;
  logic [OUT_COUNT_W-1:0] s1_lcnt_q, s1_rcnt_q, s2_lcnt_q, s2_rcnt_q;
  logic [OUT_COUNT_W-1:0] s3_lcnt_q, s3_rcnt_q;
  logic [OUT_COUNT_W-1:0] lcnt_next, rcnt_next;

  // Stage combinational values.
  logic [COUNT_BITS-1:0]  ml_next, mr_next;
  logic                   err_ge;
  logic [DiffW-1:0]       err_mag;
  logic [ERR_W-1:0]       err_sat;
  logic signed [ERR_W-1:0] err_next;
  logic signed [SUM_W-1:0] prod, sum, lim;
  logic signed [TARGET_W-1:0] applied;
  logic                   applied_neg, applied_pos;
  logic [TARGET_W-1:0]    applied_abs;

  // Handshake: each stage loads when it is empty or its content moves on.
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign s3_ready    = !s3_valid_q || out_ready;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign in_fire     = in_valid_i && s1_ready;
  assign in_stall_o  = !s1_ready;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_gain_q     <= SYNC_GAIN_RST;
      max_drive_q     <= MAX_DRIVE_RST;
      reverse_right_q <= REVERSE_RIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SYNC_GAIN:     sync_gain_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_MAX_DRIVE:     max_drive_q     <= cfg_data_i;
        CFG_REVERSE_RIGHT: reverse_right_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Next positions for the accepted request.
  always_comb begin
    left_pos_d  = left_pos_q;
    right_pos_d = right_pos_q;
    case (kind_e'(kind_i))
      KIND_SAMPLE: begin
        left_pos_d  = left_pos_q + COUNT_BITS'(STEP_TABLE[{left_ab_i, last_left_q}]);
        right_pos_d = right_pos_q + COUNT_BITS'(STEP_TABLE[{right_ab_i, last_right_q}]);
      end
      KIND_CLEAR: begin
        left_pos_d  = '0;
        right_pos_d = '0;
      end
      default: ;
    endcase
  end

  // Counts as reported: sign-extended or truncated to the field width.
  assign lcnt_next = OUT_COUNT_W'(64'($signed(left_pos_d)));
  assign rcnt_next = OUT_COUNT_W'(64'($signed(right_pos_d)));

  // Wheel state updates at acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_left_q  <= '0;
      last_right_q <= '0;
      left_pos_q   <= '0;
      right_pos_q  <= '0;
      left_snap_q  <= '0;
      right_snap_q <= '0;
    end else if (in_fire) begin
      left_pos_q  <= left_pos_d;
      right_pos_q <= right_pos_d;
      if (kind_e'(kind_i) == KIND_SAMPLE) begin
        last_left_q  <= left_ab_i;
        last_right_q <= right_ab_i;
      end
      if (kind_e'(kind_i) == KIND_TICK) begin
        left_snap_q  <= left_pos_q;
        right_snap_q <= right_pos_q;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_fire;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Stage 1: count changes since the last tick.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_tick_q <= (kind_e'(kind_i) == KIND_TICK);
      s1_dl_q   <= left_pos_q - left_snap_q;
      s1_dr_q   <= right_pos_q - right_snap_q;
      s1_lcnt_q <= lcnt_next;
      s1_rcnt_q <= rcnt_next;
    end
  end

  // Stage 2: magnitudes of the two's complement deltas.
  assign ml_next = s1_dl_q[COUNT_BITS-1] ? -s1_dl_q : s1_dl_q;
  assign mr_next = s1_dr_q[COUNT_BITS-1] ? -s1_dr_q : s1_dr_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_tick_q <= s1_tick_q;
      s2_ml_q   <= ml_next;
      s2_mr_q   <= mr_next;
      s2_lcnt_q <= s1_lcnt_q;
      s2_rcnt_q <= s1_rcnt_q;
    end
  end

  // Stage 3: signed error |dL| - |dR|, limited in magnitude.
  always_comb begin
    err_ge  = (s2_ml_q >= s2_mr_q);
    err_mag = err_ge ? DiffW'(s2_ml_q - s2_mr_q) : DiffW'(s2_mr_q - s2_ml_q);
    err_sat = (err_mag > DiffW'(ERR_LIMIT)) ? ERR_W'(ERR_LIMIT) : ERR_W'(err_mag);
    if (!s2_tick_q) begin
      err_next = '0;
    end else if (err_ge) begin
      err_next = $signed(err_sat);
    end else begin
      err_next = -$signed(err_sat);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      s3_tick_q <= s2_tick_q;
      s3_err_q  <= err_next;
      s3_lcnt_q <= s2_lcnt_q;
      s3_rcnt_q <= s2_rcnt_q;
    end
  end

  // Output stage: target plus gain * error, clamped to the drive limit.
  // A non-tick request adds zero error, so one clamp serves both the stored
  // target and the applied drive, and it applies a lowered limit to the target.
  always_comb begin
    prod = SUM_W'($signed({1'b0, sync_gain_q}) * s3_err_q);
    sum  = prod + SUM_W'(target_q);
    lim  = $signed(SUM_W'(max_drive_q));
    if (sum > lim) begin
      applied = TARGET_W'(lim);
    end else if (sum < -lim) begin
      applied = TARGET_W'(-lim);
    end else begin
      applied = TARGET_W'(sum);
    end
    applied_neg = applied[TARGET_W-1];
    applied_pos = !applied_neg && (applied != '0);
    applied_abs = applied_neg ? TARGET_W'(-applied) : TARGET_W'(applied);
  end

  // Drive target only moves on a tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (s3_valid_q && out_ready && s3_tick_q) begin
      target_q <= applied;
    end
  end

  // Result register; reverse mode swaps the direction pins.
  always_ff @(posedge clk_i) begin
    if (s3_valid_q && out_ready) begin
      left_count_o  <= s3_lcnt_q;
      right_count_o <= s3_rcnt_q;
      drive_pin_a_o <= reverse_right_q ? applied_pos : applied_neg;
      drive_pin_b_o <= reverse_right_q ? applied_neg : applied_pos;
      drive_pwm_o   <= applied_abs[DRIVE_W-1:0];
    end
  end

endmodule

// ----- src/qdws_checker.sv -----
// ----------------------------------------------------------------------------
// Quadrature decode and wheel sync port checker
// Watches the top level's ports for handshake and drive encoding errors.
// ----------------------------------------------------------------------------
`include "quadrature_decode_wheel_sync_unit_defines.svh"

module qdws_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [qdws_pkg::OUT_COUNT_W-1:0]    left_count_o,
  input logic [qdws_pkg::OUT_COUNT_W-1:0]    right_count_o,
  input logic                                drive_pin_a_o,
  input logic                                drive_pin_b_o,
  input logic [qdws_pkg::DRIVE_W-1:0]        drive_pwm_o
);

  // A stalled result stays offered.
  `QDWS_ASSERT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")

  // A stalled result keeps its payload.
  `QDWS_ASSERT(a_out_payload_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(left_count_o) && $stable(right_count_o) && $stable(drive_pin_a_o) && $stable(drive_pin_b_o) && $stable(drive_pwm_o), "stalled result changed")

  // Requests back up only behind a full, stalled output.
  `QDWS_ASSERT(a_stall_only_when_full, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "request stalled with output free")

  // Direction pins agree with the PWM magnitude: one pin when driving, none at coast.
  `QDWS_ASSERT(a_drive_encoding, clk_i, rst_ni, out_valid_o |-> !(drive_pin_a_o && drive_pin_b_o) && ((drive_pin_a_o || drive_pin_b_o) == (drive_pwm_o != '0)), "bad sign-magnitude drive")

endmodule

bind quadrature_decode_wheel_sync_unit qdws_checker u_qdws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .left_count_o  (left_count_o),
  .right_count_o (right_count_o),
  .drive_pin_a_o (drive_pin_a_o),
  .drive_pin_b_o (drive_pin_b_o),
  .drive_pwm_o   (drive_pwm_o)
);

// ----- tb/sv/tb_quadrature_decode_wheel_sync_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadrature decode and wheel sync unit testbench
// A queue-fed driver sends pin samples, control ticks and count clears.
// A scoreboard predicts each result, and a monitor compares every field.
// The run covers several gain and limit settings and random flow control.
// ----------------------------------------------------------------------------
module tb_quadrature_decode_wheel_sync_unit;
  import qdws_pkg::*;

  localparam int                      CYCLE_LIMIT      = 1_000_000;
  localparam logic [KIND_W-1:0]       KIND_UNUSED      = 2'd3;
  localparam logic [CFG_IDX_W-1:0]    CFG_UNUSED_INDEX = 2'd3;
  localparam longint                  ERR_CAP          = 65536;

  // Position change for each {new pins, previous pins} pair.
  localparam int QUAD_STEP [16] = '{
    0, 1, -1, 2,
    -1, 0, -2, 1,
    1, -2, 0, -1,
    2, -1, 1, 0
  };

  // Pin walk that visits every pair of previous and new pins.
  localparam logic [PINS_W-1:0] PAIR_WALK [16] = '{
    2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
    2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0
  };

  typedef enum int {
    FLOW_FREE,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PINS_W-1:0] left_ab;
    logic [PINS_W-1:0] right_ab;
  } wheel_request_t;

  typedef struct packed {
    logic [OUT_COUNT_W-1:0] left_count;
    logic [OUT_COUNT_W-1:0] right_count;
    logic                   pin_a;
    logic                   pin_b;
    logic [DRIVE_W-1:0]     pwm;
  } wheel_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [KIND_W-1:0]     kind_i;
  logic [PINS_W-1:0]     left_ab_i;
  logic [PINS_W-1:0]     right_ab_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [OUT_COUNT_W-1:0] left_count_o;
  logic signed [OUT_COUNT_W-1:0] right_count_o;
  logic                  drive_pin_a_o;
  logic                  drive_pin_b_o;
  logic [DRIVE_W-1:0]    drive_pwm_o;

  wheel_request_t pending_requests[$];
  wheel_result_t  expected_wheel_results[$];
  flow_e          flow_mode;
  logic           request_taken;
  int             mismatches;
  int             cycle_count;

  // Pins most recently queued, so generated walks continue from them.
  logic [PINS_W-1:0] gen_left_pins;
  logic [PINS_W-1:0] gen_right_pins;

  // Scoreboard copy of the registers and the wheel state.
  logic [GAIN_W-1:0]  model_gain;
  logic [DRIVE_W-1:0] model_max_drive;
  logic               model_reverse;
  logic [PINS_W-1:0]  prev_left_pins;
  logic [PINS_W-1:0]  prev_right_pins;
  logic [31:0]        left_pos;
  logic [31:0]        right_pos;
  logic [31:0]        left_pos_at_tick;
  logic [31:0]        right_pos_at_tick;
  longint             drive_target;

  quadrature_decode_wheel_sync_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .left_ab_i     (left_ab_i),
    .right_ab_i    (right_ab_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_count_o  (left_count_o),
    .right_count_o (right_count_o),
    .drive_pin_a_o (drive_pin_a_o),
    .drive_pin_b_o (drive_pin_b_o),
    .drive_pwm_o   (drive_pwm_o)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Magnitude of a wrapped count change, read as two's complement.
  function automatic logic [31:0] tick_span(logic [31:0] now_pos, logic [31:0] tick_pos);
    logic [31:0] diff;
    diff = now_pos - tick_pos;
    return diff[31] ? -diff : diff;
  endfunction

  function automatic longint clamp_drive_level(longint level);
    longint lim;
    lim = longint'(model_max_drive);
    if (level > lim) level = lim;
    if (level < -lim) level = -lim;
    return level;
  endfunction

  // Advances the scoreboard state by one request and returns its result.
  function automatic wheel_result_t predict_wheel_result(wheel_request_t req);
    wheel_result_t res;
    logic [31:0]   span_l;
    logic [31:0]   span_r;
    logic [31:0]   gap;
    longint        err;
    longint        drive;
    case (req.kind)
      KIND_SAMPLE: begin
        left_pos        = left_pos + QUAD_STEP[{req.left_ab, prev_left_pins}];
        right_pos       = right_pos + QUAD_STEP[{req.right_ab, prev_right_pins}];
        prev_left_pins  = req.left_ab;
        prev_right_pins = req.right_ab;
      end
      KIND_TICK: begin
        span_l = tick_span(left_pos, left_pos_at_tick);
        span_r = tick_span(right_pos, right_pos_at_tick);
        left_pos_at_tick  = left_pos;
        right_pos_at_tick = right_pos;
        // The error magnitude is capped before the gain multiply.
        if (span_l >= span_r) begin
          gap = span_l - span_r;
          err = (gap > ERR_CAP) ? ERR_CAP : longint'(gap);
        end else begin
          gap = span_r - span_l;
          err = (gap > ERR_CAP) ? -ERR_CAP : -longint'(gap);
        end
        drive_target = clamp_drive_level(drive_target + longint'(model_gain) * err);
      end
      KIND_CLEAR: begin
        left_pos  = '0;
        right_pos = '0;
      end
      default: begin
      end
    endcase
    // The applied drive is clamped again, since the limit may have dropped.
    drive = clamp_drive_level(drive_target);
    if (model_reverse) drive = -drive;
    res.left_count  = left_pos;
    res.right_count = right_pos;
    res.pin_a       = (drive < 0);
    res.pin_b       = (drive > 0);
    res.pwm         = DRIVE_W'((drive < 0) ? -drive : drive);
    return res;
  endfunction

  function automatic bit sender_pauses();
    case (flow_mode)
      FLOW_SENDER_GAPS: return $urandom_range(0, 99) < 65;
      FLOW_BOTH:        return $urandom_range(0, 99) < 14;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (flow_mode)
      FLOW_RECEIVER_STALLS: return $urandom_range(0, 99) < 65;
      FLOW_BOTH:            return $urandom_range(0, 99) < 14;
      default:              return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Next pin pair in gray order, forward 0, 1, 3, 2.
  function automatic logic [PINS_W-1:0] gray_step(logic [PINS_W-1:0] pins, bit fwd);
    case (pins)
      2'd0:    return fwd ? 2'd1 : 2'd2;
      2'd1:    return fwd ? 2'd3 : 2'd0;
      2'd3:    return fwd ? 2'd2 : 2'd1;
      default: return fwd ? 2'd0 : 2'd3;
    endcase
  endfunction

  // Clean steps at the given rate, a little noise with double steps, otherwise standstill.
  function automatic logic [PINS_W-1:0] wheel_next_pins(logic [PINS_W-1:0] pins, int rate,
                                                        bit fwd);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < rate) return gray_step(pins, fwd);
    if (roll < rate + 6) return PINS_W'($urandom_range(0, 3));
    return pins;
  endfunction

  function automatic void queue_request(logic [KIND_W-1:0] kind, logic [PINS_W-1:0] l,
                                        logic [PINS_W-1:0] r);
    pending_requests.push_back('{kind: kind, left_ab: l, right_ab: r});
    if (kind == KIND_SAMPLE) begin
      gen_left_pins  = l;
      gen_right_pins = r;
    end
  endfunction

  // Two wheels turning at their own rates, with random ticks, clears and unused kinds.
  function automatic void queue_wheel_traffic(int count);
    int roll;
    int left_rate;
    int right_rate;
    bit left_fwd;
    bit right_fwd;
    left_rate  = $urandom_range(20, 90);
    right_rate = $urandom_range(20, 90);
    left_fwd   = 1'($urandom_range(0, 1));
    right_fwd  = 1'($urandom_range(0, 1));
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        if ($urandom_range(0, 49) == 0) left_fwd = !left_fwd;
        if ($urandom_range(0, 49) == 0) right_fwd = !right_fwd;
        queue_request(KIND_SAMPLE, wheel_next_pins(gen_left_pins, left_rate, left_fwd),
                      wheel_next_pins(gen_right_pins, right_rate, right_fwd));
      end else if (roll < 93) begin
        queue_request(KIND_TICK, PINS_W'($urandom), PINS_W'($urandom));
      end else if (roll < 96) begin
        queue_request(KIND_CLEAR, PINS_W'($urandom), PINS_W'($urandom));
      end else begin
        queue_request(KIND_UNUSED, PINS_W'($urandom), PINS_W'($urandom));
      end
    end
  endfunction

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SYNC_GAIN:     model_gain      = data[GAIN_W-1:0];
      CFG_MAX_DRIVE:     model_max_drive = data[DRIVE_W-1:0];
      CFG_REVERSE_RIGHT: model_reverse   = data[0];
      default: begin
      end
    endcase
  endtask

  // Unused upper data bits carry noise that the unit must ignore.
  task automatic apply_settings(logic [GAIN_W-1:0] gain, logic [DRIVE_W-1:0] limit,
                                logic reverse);
    write_register(CFG_SYNC_GAIN, {7'($urandom), gain});
    write_register(CFG_MAX_DRIVE, limit);
    write_register(CFG_REVERSE_RIGHT, {14'($urandom), reverse});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_until_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_wheel_results.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Accepted requests go into the scoreboard at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_wheel_results.push_back(predict_wheel_result('{kind: kind_i,
                                                              left_ab: left_ab_i,
                                                              right_ab: right_ab_i}));
      request_taken <= 1'b1;
    end else begin
      request_taken <= 1'b0;
    end
  end

  // Request driver: holds a stalled request, otherwise loads the next one.
  always @(negedge clk_i) begin
    wheel_request_t next_req;
    if (rst_ni && (!in_valid_i || request_taken)) begin
      if (pending_requests.size() != 0 && !sender_pauses()) begin
        next_req   = pending_requests.pop_front();
        in_valid_i <= 1'b1;
        kind_i     <= next_req.kind;
        left_ab_i  <= next_req.left_ab;
        right_ab_i <= next_req.right_ab;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= receiver_stalls();
  end

  // Result monitor.
  always @(posedge clk_i) begin
    wheel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_wheel_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual counts %0d %0d drive %b%b %0d",
                 $time, left_count_o, right_count_o, drive_pin_a_o, drive_pin_b_o,
                 drive_pwm_o);
        mismatches++;
      end else begin
        want = expected_wheel_results.pop_front();
        check_field("left_count", want.left_count, left_count_o);
        check_field("right_count", want.right_count, right_count_o);
        check_field("drive_pin_a", 32'(want.pin_a), 32'(drive_pin_a_o));
        check_field("drive_pin_b", 32'(want.pin_b), 32'(drive_pin_b_o));
        check_field("drive_pwm", 32'(want.pwm), 32'(drive_pwm_o));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               expected_wheel_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [GAIN_W-1:0]  gain;
    logic [DRIVE_W-1:0] limit;
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    kind_i            = '0;
    left_ab_i         = '0;
    right_ab_i        = '0;
    out_stall_i       = 1'b0;
    request_taken     = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    flow_mode         = FLOW_FREE;
    gen_left_pins     = '0;
    gen_right_pins    = '0;
    model_gain        = SYNC_GAIN_RST;
    model_max_drive   = MAX_DRIVE_RST;
    model_reverse     = REVERSE_RIGHT_RST;
    prev_left_pins    = '0;
    prev_right_pins   = '0;
    left_pos          = '0;
    right_pos         = '0;
    left_pos_at_tick  = '0;
    right_pos_at_tick = '0;
    drive_target      = 0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests under reset settings: ignored kind and pins, every pin
    // pair on the left wheel and all but one on the right, then a tick across a clear.
    queue_request(KIND_UNUSED, 2'd3, 2'd3);
    queue_request(KIND_TICK, 2'd2, 2'd1);
    foreach (PAIR_WALK[i]) queue_request(KIND_SAMPLE, PAIR_WALK[i], PAIR_WALK[i] ^ 2'b11);
    queue_request(KIND_TICK, 2'd3, 2'd0);
    queue_request(KIND_CLEAR, 2'd1, 2'd2);
    queue_request(KIND_TICK, 2'd0, 2'd3);
    queue_request(KIND_UNUSED, 2'd0, 2'd0);
    wait_until_drained();

    // Random traffic across several settings and flow patterns.
    write_register(CFG_UNUSED_INDEX, CFG_DATA_W'($urandom));
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: apply_settings(8'd255, 15'd32767, 1'b1);
        1: apply_settings(8'd0, 15'd0, 1'b0);
        2: apply_settings(8'd1, 15'd1, 1'b1);
        3: apply_settings(SYNC_GAIN_RST, MAX_DRIVE_RST, 1'b0);
        default: begin
          gain  = GAIN_W'($urandom_range(0, 255));
          limit = ($urandom_range(0, 3) == 0) ? DRIVE_W'($urandom_range(0, 32767))
                                              : DRIVE_W'($urandom_range(200, 5000));
          apply_settings(gain, limit, 1'($urandom_range(0, 1)));
        end
      endcase
      flow_mode = flow_e'(phase % 4);
      queue_wheel_traffic(160);
      wait_until_drained();
    end

    // Long left run of double steps; with zero gain the target holds.
    flow_mode = FLOW_FREE;
    apply_settings(8'd0, 15'd20000, 1'b0);
    queue_request(KIND_TICK, 2'd0, 2'd0);
    repeat (100) queue_request(KIND_SAMPLE, gen_left_pins ^ 2'b11, gen_right_pins);
    queue_request(KIND_TICK, 2'd0, 2'd0);
    wait_until_drained();

    // Long right run of double steps at full gain saturates the drive.
    apply_settings(8'd255, 15'd32767, 1'b1);
    queue_request(KIND_TICK, 2'd0, 2'd0);
    repeat (100) queue_request(KIND_SAMPLE, gen_left_pins, gen_right_pins ^ 2'b11);
    queue_request(KIND_TICK, 2'd0, 2'd0);
    flow_mode = FLOW_BOTH;
    queue_wheel_traffic(60);
    wait_until_drained();

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
